// ===== src/ftvsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftvsp_pkg
// Shared types and constants of the tag=value stream parser.
// ----------------------------------------------------------------------------
package ftvsp_pkg;

	localparam int unsigned MESSAGE_BYTES_MAX = 65536;
	localparam logic [15:0] POS_CAP = (MESSAGE_BYTES_MAX < 65536) ?
		16'(MESSAGE_BYTES_MAX - 1) : 16'hFFFF;
	localparam logic [19:0] TAG_MAX = 20'hFFFFF;
	localparam logic [31:0] VAL_MAX = 32'hFFFFFFFF;
	localparam logic [7:0]  CHAR_EQ = 8'h3D;
	localparam logic [7:0]  CHAR_0 = 8'h30;
	localparam logic [7:0]  CHAR_9 = 8'h39;
	localparam logic [19:0] TAG_BODY_LEN = 20'd9;
	localparam logic [19:0] TAG_CHECKSUM = 20'd10;
	localparam logic [19:0] TAG_MSG_TYPE = 20'd35;
	localparam logic [7:0]  DELIM_RESET = 8'h01;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_EQUALS = 3'd1,
		ST_BAD_TAG = 3'd2,
		ST_EMPTY = 3'd3,
		ST_LENGTH = 3'd4,
		ST_CHECKSUM = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_TAG = 3'b001,
		PH_VALUE = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [19:0] tag;
		logic [31:0] value_number;
		logic        value_numeric;
		logic [15:0] value_start;
		logic [15:0] value_length;
		logic [2:0]  status;
		logic        message_end;
	} out_item_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       delim;
		logic       digit;
		logic       equals;
		logic [3:0] digit_val;
	} cls_item_t;

endpackage

// ===== src/fix_tag_value_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// fix_tag_value_stream_parser_unit
// Splits a byte stream into tag=value fields and checks length and checksum.
// ----------------------------------------------------------------------------
// One byte per cycle sustained: every stage does constant work per byte and
// stalls only while the result register holds an unaccepted result. A byte
// passes the classifier register, a two-entry queue and the field engine,
// whose result register is the output.
module fix_tag_value_stream_parser_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ftvsp_pkg::in_item_t    in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ftvsp_pkg::out_item_t   out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data
);

	logic [7:0] delim_q;
	logic                 f_valid, f_ready, b_valid, b_ready;
	ftvsp_pkg::cls_item_t f_data, b_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= ftvsp_pkg::DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= cfg_data;
		end
	end

	ftvsp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.delimiter(delim_q),
		.cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
	);

	ftvsp_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
	);

	ftvsp_back u_back (
		.clk, .arst_n,
		.cls_valid(b_valid), .cls_ready(b_ready), .cls_data(b_data),
		.out_valid, .out_ready, .out_data
	);

endmodule

// ===== src/ftvsp_front.sv =====
// ----------------------------------------------------------------------------
// ftvsp_front
// Accepts raw bytes and classifies them against the delimiter.
// ----------------------------------------------------------------------------
module ftvsp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ftvsp_pkg::in_item_t    in_data,
	input  logic [7:0]             delimiter,
	output logic                   cls_valid,
	input  logic                   cls_ready,
	output ftvsp_pkg::cls_item_t   cls_data
);

	ftvsp_pkg::cls_item_t item_s1;
	logic                 valid_s1;

	assign in_ready = !valid_s1 || cls_ready;
	assign cls_valid = valid_s1;
	assign cls_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data_byte <= in_data.data_byte;
			item_s1.last_byte <= in_data.last_byte;
			item_s1.delim <= (in_data.data_byte == delimiter);
			item_s1.digit <= (in_data.data_byte >= ftvsp_pkg::CHAR_0) &&
				(in_data.data_byte <= ftvsp_pkg::CHAR_9);
			item_s1.equals <= (in_data.data_byte == ftvsp_pkg::CHAR_EQ);
			item_s1.digit_val <= 4'(in_data.data_byte - ftvsp_pkg::CHAR_0);
		end
	end

endmodule

// ===== src/ftvsp_fifo.sv =====
// ----------------------------------------------------------------------------
// ftvsp_fifo
// Two-entry queue between classifier and field engine.
// ----------------------------------------------------------------------------
module ftvsp_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_valid,
	output logic                   wr_ready,
	input  ftvsp_pkg::cls_item_t   wr_data,
	output logic                   rd_valid,
	input  logic                   rd_ready,
	output ftvsp_pkg::cls_item_t   rd_data
);

	ftvsp_pkg::cls_item_t mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data = mem_q[rptr_q];
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) wptr_q <= !wptr_q;
			if (rd_en) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/ftvsp_back.sv =====
// ----------------------------------------------------------------------------
// ftvsp_back
// Field engine: accumulates tag and value, checks length and checksum.
// ----------------------------------------------------------------------------
module ftvsp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cls_valid,
	output logic                   cls_ready,
	input  ftvsp_pkg::cls_item_t   cls_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ftvsp_pkg::out_item_t   out_data
);

	ftvsp_pkg::phase_t phase_q;
	logic [19:0] tag_q;
	logic [3:0]  tag_cnt_q;
	logic [31:0] val_q;
	logic        all_dig_q;
	logic [15:0] pos_q;
	logic [15:0] fstart_q;
	logic [15:0] vstart_q;
	logic [7:0]  sum_q;
	logic [7:0]  fsum_q;
	logic [31:0] claim_q;
	logic        claim_seen_q;
	logic [15:0] mt_start_q;
	logic        mt_seen_q;
	logic        ovalid_q;
	ftvsp_pkg::out_item_t odata_q;

	logic        take;
	logic [15:0] next_pos;
	logic [7:0]  sum_n;
	logic [23:0] tag_mul;
	logic [19:0] tag_n;
	logic [35:0] val_mul;
	logic [31:0] val_n;
	logic        emit;
	logic        to_new;
	logic        fld_ok;
	logic        hold;
	logic [2:0]  st;
	logic        wv;
	logic [15:0] len;
	logic [15:0] end_pos;
	logic [15:0] body;
	logic [31:0] val_out;
	logic        num_out;
	logic        tag_dig;

	assign cls_ready = !ovalid_q || out_ready;
	assign take = cls_valid && cls_ready;
	assign out_valid = ovalid_q;
	assign out_data = odata_q;
	assign next_pos = (pos_q < ftvsp_pkg::POS_CAP) ? pos_q + 16'd1 : ftvsp_pkg::POS_CAP;
	assign sum_n = sum_q + (cls_data.delim ? 8'd1 : cls_data.data_byte);
	assign tag_mul = 24'(tag_q) * 24'd10 + 24'(cls_data.digit_val);
	assign tag_n = (tag_mul > 24'(ftvsp_pkg::TAG_MAX)) ? ftvsp_pkg::TAG_MAX : tag_mul[19:0];
	assign val_mul = 36'(val_q) * 36'd10 + 36'(cls_data.digit_val);
	assign val_n = (val_mul > 36'(ftvsp_pkg::VAL_MAX)) ? ftvsp_pkg::VAL_MAX : val_mul[31:0];
	assign end_pos = cls_data.delim ? pos_q : next_pos;
	assign len = end_pos - vstart_q;
	assign body = fstart_q - mt_start_q;
	assign val_out = (cls_data.delim || !cls_data.digit) ? val_q : val_n;
	assign num_out = all_dig_q && (cls_data.delim || cls_data.digit);
	assign tag_dig = (phase_q == ftvsp_pkg::PH_TAG) && !cls_data.delim &&
		!cls_data.equals && cls_data.digit;

	always_comb begin
		emit = 1'b0;
		st = ftvsp_pkg::ST_OK;
		wv = 1'b0;
		hold = 1'b0;
		unique case (phase_q)
			ftvsp_pkg::PH_TAG: begin
				if (cls_data.delim) begin
					emit = 1'b1;
					st = ftvsp_pkg::ST_NO_EQUALS;
				end else if (cls_data.equals) begin
					if (tag_cnt_q == 4'd0) begin
						emit = 1'b1;
						st = ftvsp_pkg::ST_BAD_TAG;
					end else if (cls_data.last_byte) begin
						emit = 1'b1;
						st = ftvsp_pkg::ST_EMPTY;
						wv = 1'b1;
					end
				end else if (cls_data.digit) begin
					if (cls_data.last_byte) begin
						emit = 1'b1;
						st = ftvsp_pkg::ST_NO_EQUALS;
					end
				end else begin
					emit = 1'b1;
					st = ftvsp_pkg::ST_BAD_TAG;
				end
			end
			ftvsp_pkg::PH_VALUE: begin
				if (cls_data.delim || cls_data.last_byte) begin
					emit = 1'b1;
					wv = 1'b1;
					if (len == 16'd0) begin
						st = ftvsp_pkg::ST_EMPTY;
					end else if (tag_q == ftvsp_pkg::TAG_CHECKSUM) begin
						if (!num_out || val_out != 32'(fsum_q)) begin
							st = ftvsp_pkg::ST_CHECKSUM;
						end else if (claim_seen_q && (!mt_seen_q || claim_q != 32'(body))) begin
							st = ftvsp_pkg::ST_LENGTH;
						end
					end
				end
			end
			default: hold = 1'b1;
		endcase
	end

	assign fld_ok = (st == ftvsp_pkg::ST_OK);
	assign to_new = cls_data.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			phase_q <= ftvsp_pkg::PH_TAG;
			tag_q <= '0;
			tag_cnt_q <= '0;
			val_q <= '0;
			all_dig_q <= 1'b1;
			pos_q <= '0;
			fstart_q <= '0;
			vstart_q <= '0;
			sum_q <= '0;
			fsum_q <= '0;
			claim_q <= '0;
			claim_seen_q <= 1'b0;
			mt_start_q <= '0;
			mt_seen_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) ovalid_q <= 1'b0;
			if (take) begin
				if (emit) ovalid_q <= 1'b1;
				sum_q <= sum_n;
				pos_q <= next_pos;
				if (phase_q == ftvsp_pkg::PH_TAG && !cls_data.delim) begin
					if (cls_data.equals && tag_cnt_q != 4'd0) begin
						if (tag_q == ftvsp_pkg::TAG_MSG_TYPE && !mt_seen_q) begin
							mt_seen_q <= 1'b1;
							mt_start_q <= fstart_q;
						end
						vstart_q <= next_pos;
						val_q <= '0;
						all_dig_q <= 1'b1;
						phase_q <= ftvsp_pkg::PH_VALUE;
					end else if (cls_data.digit) begin
						tag_q <= tag_n;
						if (tag_cnt_q != 4'd15) tag_cnt_q <= tag_cnt_q + 4'd1;
					end
				end
				if (phase_q == ftvsp_pkg::PH_VALUE && !cls_data.delim) begin
					if (cls_data.digit) val_q <= val_n;
					else all_dig_q <= 1'b0;
				end
				if (phase_q == ftvsp_pkg::PH_VALUE && emit && len != 16'd0 &&
					tag_q == ftvsp_pkg::TAG_BODY_LEN) begin
					claim_q <= num_out ? val_out : ftvsp_pkg::VAL_MAX;
					claim_seen_q <= 1'b1;
				end
				if (emit && fld_ok && !to_new) begin
					phase_q <= ftvsp_pkg::PH_TAG;
					tag_q <= '0;
					tag_cnt_q <= '0;
					fstart_q <= next_pos;
					fsum_q <= sum_n;
				end else if (emit && !to_new) begin
					phase_q <= ftvsp_pkg::PH_SKIP;
				end
				if (to_new && (emit || hold)) begin
					phase_q <= ftvsp_pkg::PH_TAG;
					tag_q <= '0;
					tag_cnt_q <= '0;
					val_q <= '0;
					all_dig_q <= 1'b1;
					pos_q <= '0;
					fstart_q <= '0;
					vstart_q <= '0;
					sum_q <= '0;
					fsum_q <= '0;
					claim_q <= '0;
					claim_seen_q <= 1'b0;
					mt_start_q <= '0;
					mt_seen_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			odata_q.tag <= tag_dig ? tag_n : tag_q;
			odata_q.status <= st;
			odata_q.message_end <= !fld_ok || to_new;
			if (phase_q == ftvsp_pkg::PH_VALUE) begin
				odata_q.value_number <= val_out;
				odata_q.value_numeric <= num_out && (len != 16'd0);
				odata_q.value_start <= vstart_q;
				odata_q.value_length <= len;
			end else begin
				odata_q.value_number <= '0;
				odata_q.value_numeric <= 1'b0;
				odata_q.value_start <= wv ? next_pos : 16'd0;
				odata_q.value_length <= '0;
			end
		end
	end

endmodule

// ===== sim/fix_tag_value_stream_parser_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fix_tag_value_stream_parser_checker
// Watches the byte, result and delimiter channels of the parser, predicts
// every field result from the accepted bytes and compares each result, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module fix_tag_value_stream_parser_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  ftvsp_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  ftvsp_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [7:0]           cfg_data,
	output int                   fail_count,
	output int                   pending
);
	import ftvsp_pkg::*;

	out_item_t  field_q[$];
	logic [7:0] delim_q;
	phase_t     ph;
	logic [19:0] tag_acc;
	logic [3:0]  tag_cnt;
	logic [31:0] val_acc;
	bit          all_dig;
	logic [15:0] pos_q;
	logic [15:0] fld_start;
	logic [15:0] val_start;
	logic [7:0]  sum_q;
	logic [7:0]  sum_fld;
	logic [31:0] len_claim;
	bit          claim_seen;
	logic [15:0] mt_start;
	bit          mt_seen;

	assign pending = field_q.size();

	task automatic clear_message();
		ph = PH_TAG;
		tag_acc = '0;
		tag_cnt = '0;
		val_acc = '0;
		all_dig = 1'b1;
		pos_q = '0;
		fld_start = '0;
		val_start = '0;
		sum_q = '0;
		sum_fld = '0;
		len_claim = '0;
		claim_seen = 1'b0;
		mt_start = '0;
		mt_seen = 1'b0;
	endtask

	task automatic parse_byte(input in_item_t it);
		logic [7:0]  b;
		bit          last;
		bit          is_delim;
		bit          is_digit;
		int unsigned d;
		logic [15:0] nxt;
		logic [15:0] end_pos;
		logic [15:0] len;
		status_t     st;
		bit          with_val;
		bit          emit;
		out_item_t   r;
		b = it.data_byte;
		last = it.last_byte;
		is_delim = (b == delim_q);
		is_digit = (b >= CHAR_0 && b <= CHAR_9);
		d = b - CHAR_0;
		nxt = (pos_q < POS_CAP) ? pos_q + 16'd1 : POS_CAP;
		st = ST_OK;
		with_val = 0;
		emit = 0;
		len = '0;
		sum_q = sum_q + (is_delim ? 8'd1 : b);
		case (ph)
			PH_TAG: begin
				if (is_delim) begin
					st = ST_NO_EQUALS;
					emit = 1;
				end else if (b == CHAR_EQ) begin
					if (tag_cnt == 0) begin
						st = ST_BAD_TAG;
						emit = 1;
					end else begin
						if (tag_acc == TAG_MSG_TYPE && !mt_seen) begin
							mt_seen = 1;
							mt_start = fld_start;
						end
						val_start = nxt;
						val_acc = '0;
						all_dig = 1;
						ph = PH_VALUE;
						if (last) begin
							st = ST_EMPTY;
							with_val = 1;
							emit = 1;
						end
					end
				end else if (is_digit) begin
					if (32'(tag_acc) > (32'(TAG_MAX) - d) / 10)
						tag_acc = TAG_MAX;
					else
						tag_acc = 20'(tag_acc * 10 + d);
					if (tag_cnt < 15)
						tag_cnt = tag_cnt + 4'd1;
					if (last) begin
						st = ST_NO_EQUALS;
						emit = 1;
					end
				end else begin
					st = ST_BAD_TAG;
					emit = 1;
				end
			end
			PH_VALUE: begin
				if (!is_delim) begin
					if (is_digit) begin
						if (64'(val_acc) > (64'(VAL_MAX) - d) / 10)
							val_acc = VAL_MAX;
						else
							val_acc = 32'(val_acc * 10 + d);
					end else begin
						all_dig = 0;
					end
					end_pos = nxt;
				end else begin
					end_pos = pos_q;
				end
				if (is_delim || last) begin
					emit = 1;
					with_val = 1;
					len = end_pos - val_start;
					if (len == 0) begin
						st = ST_EMPTY;
					end else begin
						if (tag_acc == TAG_BODY_LEN) begin
							len_claim = all_dig ? val_acc : VAL_MAX;
							claim_seen = 1;
						end
						if (tag_acc == TAG_CHECKSUM) begin
							if (!all_dig || val_acc != 32'(sum_fld))
								st = ST_CHECKSUM;
							else if (claim_seen && (!mt_seen ||
								len_claim != 32'(16'(fld_start - mt_start))))
								st = ST_LENGTH;
						end
					end
				end
			end
			default: ;
		endcase
		if (emit) begin
			r.tag = tag_acc;
			r.value_number = with_val ? val_acc : '0;
			r.value_numeric = with_val && all_dig && len != 0;
			r.value_start = with_val ? val_start : '0;
			r.value_length = with_val ? len : '0;
			r.status = st;
			r.message_end = (st != ST_OK) || last;
			field_q.push_back(r);
		end
		if (last) begin
			clear_message();
		end else begin
			pos_q = nxt;
			if (emit && st != ST_OK) begin
				ph = PH_SKIP;
			end else if (emit) begin
				ph = PH_TAG;
				tag_acc = '0;
				tag_cnt = '0;
				fld_start = nxt;
				sum_fld = sum_q;
			end
		end
	endtask

	function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %0d actual %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			fail_count <= 0;
			delim_q = DELIM_RESET;
			clear_message();
		end else begin
			if (out_valid && out_ready) begin
				if (field_q.size() == 0) begin
					$error("result with no prediction waiting");
					fail_count <= fail_count + 1;
				end else begin
					e = field_q.pop_front();
					fail_count <= fail_count
						+ check_field("tag", 32'(e.tag), 32'(out_data.tag))
						+ check_field("value_number", e.value_number,
							out_data.value_number)
						+ check_field("value_numeric", 32'(e.value_numeric),
							32'(out_data.value_numeric))
						+ check_field("value_start", 32'(e.value_start),
							32'(out_data.value_start))
						+ check_field("value_length", 32'(e.value_length),
							32'(out_data.value_length))
						+ check_field("status", 32'(e.status), 32'(out_data.status))
						+ check_field("message_end", 32'(e.message_end),
							32'(out_data.message_end));
				end
			end
			if (cfg_valid && cfg_ready)
				delim_q = cfg_data;
			if (in_valid && in_ready)
				parse_byte(in_data);
		end
	end

endmodule

// ===== sim/fix_tag_value_stream_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fix_tag_value_stream_parser_unit_tb
// Feeds the parser directed corner fragments, then well-formed, corrupted and
// noise messages under several delimiters with random idling on both sides,
// ending with one long all-digit message; the checker scores every result.
// ----------------------------------------------------------------------------
module fix_tag_value_stream_parser_unit_tb;
	import ftvsp_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 0;
	out_item_t  out_data;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;
	int         fail_count;
	int         pending;
	bit         idle_en = 1;
	int         stall_left = 0;
	int         quiet_cycles = 0;
	int         sent = 0;
	logic [7:0] cur_delim = DELIM_RESET;
	logic [7:0] msg_q[$];

	fix_tag_value_stream_parser_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	fix_tag_value_stream_parser_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1;
		#5;
		clk = 0;
		#5;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 11);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
			|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit last);
		if (idle_en && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{data_byte: b, last_byte: last};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_message();
		foreach (msg_q[i])
			send_byte(msg_q[i], i == msg_q.size() - 1);
		msg_q.delete();
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_q.push_back(s[i]);
	endtask

	task automatic push_field(input string tag_txt, input string val_txt);
		push_str({tag_txt, "=", val_txt});
		msg_q.push_back(cur_delim);
	endtask

	task automatic push_value();
		int n;
		case ($urandom_range(0, 3))
			0: push_str($sformatf("%0d", $urandom_range(0, 9999)));
			1: begin
				n = $urandom_range(1, 14);
				repeat (n) msg_q.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
			end
			2: begin
				n = $urandom_range(1, 8);
				repeat (n) msg_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
			end
			default: begin
				n = $urandom_range(1, 6);
				repeat (n) msg_q.push_back(8'($urandom));
			end
		endcase
		msg_q.push_back(cur_delim);
	endtask

	task automatic build_good_message(input bit bad_sum, input bit bad_len);
		logic [7:0] body[$];
		logic [7:0] sum;
		int n;
		push_field("35", $sformatf("%c", $urandom_range(8'h41, 8'h5A)));
		n = $urandom_range(0, 5);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0: push_str("9=");
				1: push_str("35=");
				2: push_str($sformatf("%0d=", $urandom_range(1000000, 99999999)));
				default: push_str($sformatf("%0d=", $urandom_range(11, 9999)));
			endcase
			push_value();
		end
		body = msg_q;
		msg_q.delete();
		push_field("8", "FIX.4.4");
		push_field("9", $sformatf("%0d", body.size() + (bad_len ? 1 : 0)));
		foreach (body[i]) msg_q.push_back(body[i]);
		sum = '0;
		foreach (msg_q[i]) sum += (msg_q[i] == cur_delim) ? 8'd1 : msg_q[i];
		push_field("10", $sformatf("%0d", sum + (bad_sum ? 8'd1 : 8'd0)));
	endtask

	task automatic random_message();
		int n;
		int k;
		k = $urandom_range(0, 19);
		if (k < 3) begin
			n = $urandom_range(1, 24);
			repeat (n) msg_q.push_back(8'($urandom));
		end else begin
			build_good_message(k == 3, k == 4);
			if (k >= 5 && k < 8)
				msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
			if (k == 8)
				repeat ($urandom_range(1, 3)) void'(msg_q.pop_back());
		end
		send_message();
	endtask

	task automatic write_delim(input logic [7:0] d);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		cur_delim = d;
	endtask

	initial begin
		logic [7:0] delims[6];
		int goal;
		delims = '{8'h01, 8'h7C, 8'h00, 8'hFF, 8'($urandom), 8'h01};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		push_str("12=");
		send_message();
		msg_q.push_back(cur_delim);
		send_message();
		push_str("=5");
		send_message();
		push_str("4x");
		send_message();
		push_str("7");
		send_message();
		push_str("5=");
		msg_q.push_back(cur_delim);
		send_message();
		push_str("5=");
		msg_q.push_back(8'hFF);
		msg_q.push_back(8'h00);
		send_message();
		push_str("9=z");
		msg_q.push_back(cur_delim);
		push_str("10=0");
		send_message();

		foreach (delims[p]) begin
			write_delim(delims[p]);
			if (p == 5)
				idle_en = 0;
			goal = sent + 250;
			while (sent < goal)
				random_message();
		end

		push_str("1=");
		repeat (40) msg_q.push_back(8'h37);
		send_message();
		in_valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ftvsp_pkg.sv
src/ftvsp_front.sv
src/ftvsp_fifo.sv
src/ftvsp_back.sv
src/fix_tag_value_stream_parser_unit.sv
sim/fix_tag_value_stream_parser_checker.sv
sim/fix_tag_value_stream_parser_unit_tb.sv
